// ===== design/fmpf_pkg.sv =====
package fmpf_pkg;

   localparam int MAX_RULES = 64;

   // Rule count holds 0..MAX_RULES
   localparam int CNT_W = $clog2(MAX_RULES + 1);
   localparam int POS_W = 7;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

   // First-hit search runs in groups of eight cells, then across groups
   localparam int OFF_W      = 3;
   localparam int GROUP      = 1 << OFF_W;
   localparam int NUM_GROUPS = (MAX_RULES + GROUP - 1) / GROUP;
   localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int PICK_W     = GRP_W + OFF_W;
   localparam int HIT_PAD    = NUM_GROUPS * GROUP;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [7:0] CODE_TCP  = 8'd1;
   localparam logic [7:0] CODE_UDP  = 8'd2;

   typedef enum logic [1:0] {
      MODE_CLASSIFY = 2'd0,
      MODE_APPEND   = 2'd1,
      MODE_DELETE   = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_GROUP,
      ST_RESOLVE
   } state_type;

   typedef struct packed {
      logic        direction;
      logic [7:0]  code;
      logic        drop_action;
      logic [31:0] src_addr;
      logic [31:0] src_mask;
      logic [31:0] dst_addr;
      logic [31:0] dst_mask;
      logic [15:0] source_port;
      logic [15:0] dst_port;
   } rule_type;

   typedef struct packed {
      logic        direction;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] source_port;
      logic [15:0] dst_port;
   } header_type;

   typedef struct packed {
      logic live;
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic              found;
      logic              drop;
      logic [PICK_W-1:0] index;
   } pick_type;

endpackage

// ===== design/first_match_packet_rule_filter_top.sv =====
// First-match packet rule filter.
// One request channel (req_*) carries a mode and the fields of a packet
// header or of a rule; one response channel (rsp_*) returns verdict,
// matched, match_position and status for every request, in order.
// Mode 0 classifies a header, mode 1 appends a rule at the end of the
// table (status 1 if full), mode 2 deletes the rule at a 1-based position
// and moves later rules down one place; mode 3 does nothing.
// Rules live in a row of cells, one rule per cell. All cells compare the
// header at once; delete makes each cell from the position on take the
// rule of its upper neighbor, all of them together.
// A request goes through the compare in the cells, the first hit per group
// of eight and the pick across groups before its response is valid.
// Requests are taken one at a time: a new one is accepted only after the
// last has left the resolve state; req_stall is low only in the idle state.
// A response waits in its output register while rsp_stall is high; the
// next request is still accepted, and its result holds in the pick stage
// until the output register frees.
// Reset (synchronous, active high) empties the table and drops any
// pending response; rule storage itself is not cleared.
module first_match_packet_rule_filter_top
   import fmpf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic             req_direction,
   input  logic [31:0]      req_src_addr,
   input  logic [31:0]      req_src_mask,
   input  logic [15:0]      req_source_port,
   input  logic [31:0]      req_dst_addr,
   input  logic [31:0]      req_dst_mask,
   input  logic [15:0]      req_dst_port,
   input  logic [7:0]       req_protocol,
   input  logic             req_drop_action,
   input  logic [POS_W-1:0] req_position,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_verdict,
   output logic             rsp_matched,
   output logic [POS_W-1:0] rsp_match_position,
   output logic             rsp_status
);

   state_type        state_ff;
   state_type        state_in;
   mode_type         mode_ff;
   header_type       header_ff;
   rule_type         new_rule_ff;
   logic [POS_W-1:0] pos_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             refused_ff;

   logic             rsp_valid_ff;
   logic             rsp_verdict_ff;
   logic             rsp_matched_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic             rsp_status_ff;

   logic             accept;
   logic             rsp_take;
   logic             rsp_load;
   logic             update;
   logic             full;
   logic             append_go;
   logic             delete_go;
   logic             port_proto;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] pos_ext;
   logic [PICK_W:0]  pick_pos;

   cell_ctrl_type        ctrl  [MAX_RULES];
   rule_type             rules [MAX_RULES];
   rule_type             nexts [MAX_RULES];
   logic [MAX_RULES-1:0] hits;
   logic [MAX_RULES-1:0] drops;
   pick_type             pick;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: state_in = ST_GROUP;
         ST_GROUP:   state_in = ST_RESOLVE;
         ST_RESOLVE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      update    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_stall = 1'b0;
         ST_COMPARE: update    = 1'b1;
         ST_GROUP:   rsp_load  = 1'b0;
         ST_RESOLVE: rsp_load  = !rsp_valid_ff || !rsp_stall;
         default:    req_stall = 1'b1;
      endcase
   end

   assign accept   = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   assign count_ext = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(pos_ff);
   assign full      = (count_ext >= CMP_W'(MAX_RULES));
   assign append_go = update && (mode_ff == MODE_APPEND) && !full;
   assign delete_go = update && (mode_ff == MODE_DELETE) &&
                      (pos_ff != '0) && (pos_ext <= count_ext);

   always_comb begin
      priority if (append_go) begin
         count_in = count_ff + CNT_W'(1);
      end else if (delete_go) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // ports count as zero unless TCP or UDP
   assign port_proto = (req_protocol == PROTO_TCP) || (req_protocol == PROTO_UDP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // note a refused append before the count moves
   always_ff @(posedge clock) begin
      if (update) begin
         refused_ff <= (mode_ff == MODE_APPEND) && full;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff               <= mode_type'(req_mode);
         pos_ff                <= req_position;
         header_ff.direction   <= req_direction;
         header_ff.protocol    <= req_protocol;
         header_ff.src_addr    <= req_src_addr;
         header_ff.dst_addr    <= req_dst_addr;
         header_ff.source_port <= port_proto ? req_source_port : '0;
         header_ff.dst_port    <= port_proto ? req_dst_port : '0;
         new_rule_ff.direction   <= req_direction;
         new_rule_ff.code        <= req_protocol;
         new_rule_ff.drop_action <= req_drop_action;
         new_rule_ff.src_addr    <= req_src_addr;
         new_rule_ff.src_mask    <= req_src_mask;
         new_rule_ff.dst_addr    <= req_dst_addr;
         new_rule_ff.dst_mask    <= req_dst_mask;
         new_rule_ff.source_port <= req_source_port;
         new_rule_ff.dst_port    <= req_dst_port;
      end
   end

   for (genvar k = 0; k < MAX_RULES; k++) begin : g_cell
      if (k + 1 < MAX_RULES) begin : g_link
         assign nexts[k] = rules[k + 1];
      end else begin : g_end
         assign nexts[k] = '0;
      end

      assign ctrl[k].live  = CMP_W'(k) < count_ext;
      assign ctrl[k].load  = append_go && (count_ext == CMP_W'(k));
      assign ctrl[k].shift = delete_go && (CMP_W'(k + 1) >= pos_ext);

      fmpf_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl[k]),
         .header    (header_ff),
         .new_rule  (new_rule_ff),
         .next_rule (nexts[k]),
         .rule      (rules[k]),
         .hit       (hits[k]),
         .drop      (drops[k])
      );
   end

   fmpf_pick u_pick (
      .clock (clock),
      .hits  (hits),
      .drops (drops),
      .pick  (pick)
   );

   assign pick_pos = {1'b0, pick.index} + (PICK_W + 1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (mode_ff == MODE_CLASSIFY) begin
            rsp_matched_ff <= pick.found;
            rsp_verdict_ff <= pick.found && pick.drop;
            rsp_pos_ff     <= pick.found ? POS_W'(pick_pos) : '0;
            rsp_status_ff  <= 1'b0;
         end else begin
            rsp_matched_ff <= 1'b0;
            rsp_verdict_ff <= 1'b0;
            rsp_pos_ff     <= '0;
            rsp_status_ff  <= refused_ff;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_matched        = rsp_matched_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// ===== design/fmpf_cell.sv =====
module fmpf_cell
   import fmpf_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  header_type    header,
   input  rule_type      new_rule,
   input  rule_type      next_rule,
   output rule_type      rule,
   output logic          hit,
   output logic          drop
);

   rule_type rule_ff;
   rule_type rule_in;
   logic     hit_ff;
   logic     hit_in;
   logic     proto_ok;
   logic     src_ok;
   logic     dst_ok;
   logic     ports_ok;

   always_comb begin
      priority if (ctrl.load) begin
         rule_in = new_rule;
      end else if (ctrl.shift) begin
         rule_in = next_rule;
      end else begin
         rule_in = rule_ff;
      end
   end

   always_comb begin
      priority if (rule_ff.code == CODE_TCP) begin
         proto_ok = (header.protocol == PROTO_TCP);
      end else if (rule_ff.code == CODE_UDP) begin
         proto_ok = (header.protocol == PROTO_UDP);
      end else begin
         proto_ok = 1'b1;
      end
      // zero rule address is a wildcard regardless of mask
      src_ok = (rule_ff.src_addr == '0) ||
               (((header.src_addr ^ rule_ff.src_addr) & rule_ff.src_mask) == '0);
      dst_ok = (rule_ff.dst_addr == '0) ||
               (((header.dst_addr ^ rule_ff.dst_addr) & rule_ff.dst_mask) == '0);
      ports_ok = ((rule_ff.source_port == '0) ||
                  (rule_ff.source_port == header.source_port)) &&
                 ((rule_ff.dst_port == '0) || (rule_ff.dst_port == header.dst_port));
      hit_in = ctrl.live && (rule_ff.direction == header.direction) &&
               proto_ok && src_ok && dst_ok && ports_ok;
   end

   always_ff @(posedge clock) begin
      rule_ff <= rule_in;
      hit_ff  <= hit_in;
   end

   assign rule = rule_ff;
   assign hit  = hit_ff;
   assign drop = ~rule_ff.drop_action;

endmodule

// ===== design/fmpf_pick.sv =====
module fmpf_pick
   import fmpf_pkg::*;
(
   input  logic                 clock,
   input  logic [MAX_RULES-1:0] hits,
   input  logic [MAX_RULES-1:0] drops,
   output pick_type             pick
);

   logic [HIT_PAD-1:0] hits_pad;
   logic [HIT_PAD-1:0] drops_pad;
   logic               grp_any_ff  [NUM_GROUPS];
   logic               grp_drop_ff [NUM_GROUPS];
   logic [OFF_W-1:0]   grp_off_ff  [NUM_GROUPS];
   logic               grp_any_in  [NUM_GROUPS];
   logic               grp_drop_in [NUM_GROUPS];
   logic [OFF_W-1:0]   grp_off_in  [NUM_GROUPS];

   assign hits_pad  = HIT_PAD'(hits);
   assign drops_pad = HIT_PAD'(drops);

   // first hit inside each group of eight
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_in[g]  = 1'b0;
         grp_drop_in[g] = 1'b0;
         grp_off_in[g]  = '0;
         for (int j = GROUP - 1; j >= 0; j--) begin
            if (hits_pad[g * GROUP + j]) begin
               grp_any_in[g]  = 1'b1;
               grp_drop_in[g] = drops_pad[g * GROUP + j];
               grp_off_in[g]  = OFF_W'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_ff[g]  <= grp_any_in[g];
         grp_drop_ff[g] <= grp_drop_in[g];
         grp_off_ff[g]  <= grp_off_in[g];
      end
   end

   // lowest group with a hit wins
   always_comb begin
      pick = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            pick.found = 1'b1;
            pick.drop  = grp_drop_ff[g];
            pick.index = {GRP_W'(g), grp_off_ff[g]};
         end
      end
   end

endmodule

// ===== verif/tb_first_match_packet_rule_filter_top.sv =====
module tb_first_match_packet_rule_filter_top;
   import fmpf_pkg::*;

   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         DRAIN_CYCLES   = 12;
   localparam logic [7:0] PROTO_ICMP     = 8'd1;

   typedef struct packed {
      mode_type         mode;
      logic             direction;
      logic [31:0]      src_addr;
      logic [31:0]      src_mask;
      logic [15:0]      source_port;
      logic [31:0]      dst_addr;
      logic [31:0]      dst_mask;
      logic [15:0]      dst_port;
      logic [7:0]       protocol;
      logic             drop_action;
      logic [POS_W-1:0] position;
   } filter_request_type;

   typedef struct packed {
      logic             verdict;
      logic             matched;
      logic [POS_W-1:0] match_position;
      logic             status;
   } filter_result_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [1:0]       req_mode;
   logic             req_direction;
   logic [31:0]      req_src_addr;
   logic [31:0]      req_src_mask;
   logic [15:0]      req_source_port;
   logic [31:0]      req_dst_addr;
   logic [31:0]      req_dst_mask;
   logic [15:0]      req_dst_port;
   logic [7:0]       req_protocol;
   logic             req_drop_action;
   logic [POS_W-1:0] req_position;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_verdict;
   logic             rsp_matched;
   logic [POS_W-1:0] rsp_match_position;
   logic             rsp_status;

   rule_type          shadow_rules [MAX_RULES];
   int                shadow_count = 0;
   filter_result_type pending_results [$];
   filter_result_type oldest;
   int                error_count = 0;
   int                idle_cycles = 0;
   bit                quiet_mode = 1'b0;

   first_match_packet_rule_filter_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_direction      (req_direction),
      .req_src_addr       (req_src_addr),
      .req_src_mask       (req_src_mask),
      .req_source_port    (req_source_port),
      .req_dst_addr       (req_dst_addr),
      .req_dst_mask       (req_dst_mask),
      .req_dst_port       (req_dst_port),
      .req_protocol       (req_protocol),
      .req_drop_action    (req_drop_action),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_verdict        (rsp_verdict),
      .rsp_matched        (rsp_matched),
      .rsp_match_position (rsp_match_position),
      .rsp_status         (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic bit rule_covers(rule_type r, logic dir, logic [7:0] proto,
                                      logic [31:0] sa, logic [31:0] da,
                                      logic [15:0] sp, logic [15:0] dp);
      return (r.direction == dir)
         && !(r.code == CODE_TCP && proto != PROTO_TCP)
         && !(r.code == CODE_UDP && proto != PROTO_UDP)
         && (r.src_addr == '0 || ((sa ^ r.src_addr) & r.src_mask) == '0)
         && (r.dst_addr == '0 || ((da ^ r.dst_addr) & r.dst_mask) == '0)
         && (r.source_port == '0 || r.source_port == sp)
         && (r.dst_port == '0 || r.dst_port == dp);
   endfunction

   function automatic filter_result_type apply_request(filter_request_type rq);
      filter_result_type res;
      rule_type          r;
      logic [15:0]       sp;
      logic [15:0]       dp;
      res = '0;
      case (rq.mode)
         MODE_CLASSIFY: begin
            sp = rq.source_port;
            dp = rq.dst_port;
            // ports count as zero unless the packet is TCP or UDP
            if (rq.protocol != PROTO_TCP && rq.protocol != PROTO_UDP) begin
               sp = '0;
               dp = '0;
            end
            for (int k = 0; k < shadow_count && !res.matched; k++) begin
               if (rule_covers(shadow_rules[k], rq.direction, rq.protocol,
                               rq.src_addr, rq.dst_addr, sp, dp)) begin
                  res.matched        = 1'b1;
                  res.match_position = POS_W'(k + 1);
                  res.verdict        = !shadow_rules[k].drop_action;
               end
            end
         end
         MODE_APPEND: begin
            if (shadow_count >= MAX_RULES) begin
               res.status = 1'b1;
            end else begin
               r.direction   = rq.direction;
               r.code        = rq.protocol;
               r.drop_action = rq.drop_action;
               r.src_addr    = rq.src_addr;
               r.src_mask    = rq.src_mask;
               r.dst_addr    = rq.dst_addr;
               r.dst_mask    = rq.dst_mask;
               r.source_port = rq.source_port;
               r.dst_port    = rq.dst_port;
               shadow_rules[shadow_count] = r;
               shadow_count++;
            end
         end
         MODE_DELETE: begin
            if (rq.position >= 1 && rq.position <= shadow_count) begin
               for (int k = rq.position - 1; k < shadow_count - 1; k++)
                  shadow_rules[k] = shadow_rules[k + 1];
               shadow_count--;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- request builders

   function automatic filter_request_type rule_request(logic dir, logic [7:0] code,
                                                       logic [31:0] sa, logic [31:0] sm,
                                                       logic [15:0] sp, logic [31:0] da,
                                                       logic [31:0] dm, logic [15:0] dp,
                                                       logic act);
      filter_request_type rq;
      rq.mode        = MODE_APPEND;
      rq.direction   = dir;
      rq.src_addr    = sa;
      rq.src_mask    = sm;
      rq.source_port = sp;
      rq.dst_addr    = da;
      rq.dst_mask    = dm;
      rq.dst_port    = dp;
      rq.protocol    = code;
      rq.drop_action = act;
      rq.position    = POS_W'($urandom);
      return rq;
   endfunction

   function automatic filter_request_type packet_request(logic dir, logic [7:0] proto,
                                                         logic [31:0] sa, logic [15:0] sp,
                                                         logic [31:0] da, logic [15:0] dp);
      filter_request_type rq;
      rq.mode        = MODE_CLASSIFY;
      rq.direction   = dir;
      rq.src_addr    = sa;
      rq.src_mask    = $urandom;
      rq.source_port = sp;
      rq.dst_addr    = da;
      rq.dst_mask    = $urandom;
      rq.dst_port    = dp;
      rq.protocol    = proto;
      rq.drop_action = 1'($urandom);
      rq.position    = POS_W'($urandom);
      return rq;
   endfunction

   function automatic filter_request_type delete_request(logic [POS_W-1:0] pos);
      filter_request_type rq;
      rq          = packet_request(1'($urandom), 8'($urandom), $urandom, 16'($urandom),
                                   $urandom, 16'($urandom));
      rq.mode     = MODE_DELETE;
      rq.position = pos;
      return rq;
   endfunction

   function automatic filter_request_type noise_request();
      filter_request_type rq;
      rq      = packet_request(1'($urandom), 8'($urandom), $urandom, 16'($urandom),
                               $urandom, 16'($urandom));
      rq.mode = mode_type'($urandom_range(0, 3));
      return rq;
   endfunction

   function automatic logic [15:0] random_port();
      if ($urandom_range(0, 1) == 0)
         return 16'($urandom);
      case ($urandom_range(0, 3))
         0:       return 16'd80;
         1:       return 16'd443;
         2:       return 16'd53;
         default: return 16'd22;
      endcase
   endfunction

   function automatic logic [15:0] random_rule_port();
      if ($urandom_range(0, 99) < 35)
         return '0;
      return random_port();
   endfunction

   function automatic logic [31:0] random_host_addr();
      if ($urandom_range(0, 99) < 20)
         return $urandom;
      case ($urandom_range(0, 2))
         0:       return 32'h0A00_0000 | ($urandom & 32'h0000_FFFF);
         1:       return 32'hC0A8_0000 | ($urandom & 32'h0000_FFFF);
         default: return 32'hAC10_0000 | ($urandom & 32'h0000_FFFF);
      endcase
   endfunction

   function automatic logic [31:0] random_rule_addr();
      if ($urandom_range(0, 99) < 20)
         return '0;
      return random_host_addr();
   endfunction

   function automatic logic [31:0] random_mask();
      if ($urandom_range(0, 99) < 15)
         return $urandom;
      return 32'hFFFF_FFFF << (32 - $urandom_range(0, 32));
   endfunction

   function automatic logic [7:0] random_protocol();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return PROTO_TCP;
      if (pick < 70) return PROTO_UDP;
      if (pick < 85) return PROTO_ICMP;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] random_code();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return CODE_TCP;
      if (pick < 60) return CODE_UDP;
      if (pick < 80) return 8'd0;
      return 8'($urandom);
   endfunction

   function automatic filter_request_type make_rule_request();
      return rule_request(1'($urandom), random_code(), random_rule_addr(), random_mask(),
                          random_rule_port(), random_rule_addr(), random_mask(),
                          random_rule_port(), 1'($urandom));
   endfunction

   // Build a packet that hits the given rule, or, when perturbed, one that may just miss it
   function automatic filter_request_type packet_for_rule(int idx, bit perturb);
      rule_type    r;
      logic        dir;
      logic [7:0]  proto;
      logic [31:0] sa;
      logic [31:0] da;
      logic [15:0] sp;
      logic [15:0] dp;
      r   = shadow_rules[idx];
      dir = r.direction;
      if (r.code == CODE_TCP)
         proto = PROTO_TCP;
      else if (r.code == CODE_UDP)
         proto = PROTO_UDP;
      else
         proto = random_protocol();
      sa = (r.src_addr == '0) ? random_host_addr()
                              : (r.src_addr & r.src_mask) | ($urandom & ~r.src_mask);
      da = (r.dst_addr == '0) ? random_host_addr()
                              : (r.dst_addr & r.dst_mask) | ($urandom & ~r.dst_mask);
      sp = (r.source_port == '0) ? random_port() : r.source_port;
      dp = (r.dst_port == '0) ? random_port() : r.dst_port;
      if (perturb) begin
         case ($urandom_range(0, 4))
            0:       dir = ~dir;
            1:       proto = 8'($urandom);
            2:       sa = sa ^ (32'd1 << $urandom_range(0, 31));
            3:       sp = sp + 16'd1;
            default: dp = 16'($urandom);
         endcase
      end
      return packet_request(dir, proto, sa, sp, da, dp);
   endfunction

   function automatic filter_request_type make_packet_request();
      if (shadow_count == 0 || $urandom_range(0, 99) < 25)
         return packet_request(1'($urandom), random_protocol(), random_host_addr(),
                               random_port(), random_host_addr(), random_port());
      return packet_for_rule($urandom_range(0, shadow_count - 1),
                             $urandom_range(0, 99) < 30);
   endfunction

   function automatic logic [POS_W-1:0] pick_delete_position();
      int pick;
      pick = $urandom_range(0, 99);
      if (shadow_count > 0 && pick < 80)
         return POS_W'($urandom_range(1, shadow_count));
      if (pick < 92)
         return POS_W'($urandom_range(shadow_count + 1, (1 << POS_W) - 1));
      return '0;
   endfunction

   // ---------------------------------------------------------------- request driver

   task automatic send_request(input filter_request_type rq);
      int gap;
      gap = 0;
      if (!quiet_mode && $urandom_range(0, 99) < 20)
         gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= rq.mode;
      req_direction   <= rq.direction;
      req_src_addr    <= rq.src_addr;
      req_src_mask    <= rq.src_mask;
      req_source_port <= rq.source_port;
      req_dst_addr    <= rq.dst_addr;
      req_dst_mask    <= rq.dst_mask;
      req_dst_port    <= rq.dst_port;
      req_protocol    <= rq.protocol;
      req_drop_action <= rq.drop_action;
      req_position    <= rq.position;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // leave valid high: the next request may follow in this very cycle
      pending_results.push_back(apply_request(rq));
   endtask

   // ---------------------------------------------------------------- response checker

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected response: verdict %0d matched %0d position %0d status %0d",
                      rsp_verdict, rsp_matched, rsp_match_position, rsp_status);
               error_count++;
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_verdict !== oldest.verdict) begin
                  $error("verdict: expected %0d, got %0d", oldest.verdict, rsp_verdict);
                  error_count++;
               end
               if (rsp_matched !== oldest.matched) begin
                  $error("matched: expected %0d, got %0d", oldest.matched, rsp_matched);
                  error_count++;
               end
               if (rsp_match_position !== oldest.match_position) begin
                  $error("match_position: expected %0d, got %0d",
                         oldest.match_position, rsp_match_position);
                  error_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_status);
                  error_count++;
               end
            end
         end
         rsp_stall <= !quiet_mode && ($urandom_range(0, 99) < 10);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[first_match_packet_rule_filter_top] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_empty_table();
      filter_request_type rq;
      send_request(packet_request(1'b0, PROTO_TCP, 32'h0A00_0001, 16'd1000,
                                  32'h0A00_0002, 16'd80));
      send_request(delete_request(7'd1));
      send_request(delete_request(7'd0));
      rq      = '1;
      rq.mode = MODE_UNUSED;
      send_request(rq);
   endtask

   task automatic test_first_match();
      send_request(rule_request(1'b0, CODE_TCP, 32'h0A00_0000, 32'hFFFF_FF00, 16'd0,
                                32'h0, 32'h0, 16'd80, 1'b0));
      send_request(rule_request(1'b0, CODE_UDP, 32'h0, 32'hFFFF_FFFF, 16'd53,
                                32'hC0A8_0100, 32'hFFFF_0000, 16'd0, 1'b1));
      send_request(rule_request(1'b1, 8'd0, 32'h0, 32'h0, 16'd0,
                                32'h0, 32'h0, 16'd0, 1'b0));
      send_request(rule_request(1'b0, 8'hFF, 32'h0, 32'h0, 16'd0,
                                32'h0, 32'h0, 16'd0, 1'b1));
      send_request(packet_request(1'b0, PROTO_TCP, 32'h0A00_0005, 16'd1234,
                                  32'h0808_0808, 16'd80));
      send_request(packet_request(1'b0, PROTO_UDP, 32'h0A00_0005, 16'd53,
                                  32'hC0A8_1234, 16'd80));
      // ICMP: ports must be ignored, so only the catch-all hits
      send_request(packet_request(1'b0, PROTO_ICMP, 32'h0A00_0005, 16'd53,
                                  32'hC0A8_1234, 16'd80));
      send_request(packet_request(1'b1, 8'hFF, 32'h1234_5678, 16'd7,
                                  32'h8765_4321, 16'd9));
      send_request(packet_request(1'b0, PROTO_TCP, 32'h0A00_0105, 16'd1,
                                  32'h0, 16'd80));
      send_request(packet_request(1'b0, PROTO_TCP, 32'h0A00_0005, 16'd1,
                                  32'h0, 16'd81));
   endtask

   task automatic test_delete_shift();
      send_request(delete_request(7'd2));
      send_request(packet_request(1'b0, PROTO_UDP, 32'h0A00_0005, 16'd53,
                                  32'hC0A8_1234, 16'd80));
      send_request(delete_request(7'd10));
      send_request(delete_request(7'd127));
      send_request(delete_request(7'd3));
      send_request(packet_request(1'b0, PROTO_ICMP, 32'h0B00_0005, 16'd0,
                                  32'h0, 16'd0));
      send_request(delete_request(7'd0));
   endtask

   task automatic test_field_extremes();
      filter_request_type rq;
      send_request(rule_request(1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
      send_request(packet_request(1'b1, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF,
                                  32'hFFFF_FFFF, 16'hFFFF));
      send_request(packet_request(1'b1, PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF,
                                  32'hFFFF_FFFF, 16'hFFFF));
      rq      = '0;
      rq.mode = MODE_UNUSED;
      send_request(rq);
   endtask

   task automatic test_full_table();
      filter_request_type rq;
      while (shadow_count > 0)
         send_request(delete_request(7'd1));
      // outgoing filler, so an incoming packet can only hit the last rule
      while (shadow_count < MAX_RULES - 1) begin
         rq           = make_rule_request();
         rq.direction = 1'b1;
         send_request(rq);
      end
      send_request(rule_request(1'b0, 8'd0, 32'h0, 32'h0, 16'd0,
                                32'h0, 32'h0, 16'd0, 1'b0));
      send_request(make_rule_request());
      send_request(make_rule_request());
      send_request(packet_request(1'b0, random_protocol(), $urandom, 16'($urandom),
                                  $urandom, 16'($urandom)));
      send_request(packet_for_rule(MAX_RULES - 1, 1'b0));
      send_request(delete_request(POS_W'(MAX_RULES)));
      send_request(delete_request(7'd1));
      send_request(make_packet_request());
   endtask

   task automatic test_random_traffic();
      int append_pct;
      int delete_pct;
      int pick;
      for (int phase = 0; phase < 6; phase++) begin
         quiet_mode = (phase == 3);
         case (phase)
            0:       begin append_pct = 55; delete_pct = 5;  end
            1:       begin append_pct = 20; delete_pct = 15; end
            2:       begin append_pct = 10; delete_pct = 45; end
            3:       begin append_pct = 30; delete_pct = 20; end
            4:       begin append_pct = 60; delete_pct = 5;  end
            default: begin append_pct = 20; delete_pct = 20; end
         endcase
         for (int n = 0; n < 140; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               send_request(noise_request());
            else if (pick < 5 + append_pct)
               send_request(make_rule_request());
            else if (pick < 5 + append_pct + delete_pct)
               send_request(delete_request(pick_delete_position()));
            else
               send_request(make_packet_request());
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= MODE_CLASSIFY;
      req_direction   <= 1'b0;
      req_src_addr    <= '0;
      req_src_mask    <= '0;
      req_source_port <= '0;
      req_dst_addr    <= '0;
      req_dst_mask    <= '0;
      req_dst_port    <= '0;
      req_protocol    <= '0;
      req_drop_action <= 1'b0;
      req_position    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_first_match();
      test_delete_shift();
      test_field_extremes();
      test_full_table();
      test_random_traffic();

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[first_match_packet_rule_filter_top] OK");
      else
         $display("[first_match_packet_rule_filter_top] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/fmpf_pkg.sv
design/fmpf_cell.sv
design/fmpf_pick.sv
design/first_match_packet_rule_filter_top.sv
verif/tb_first_match_packet_rule_filter_top.sv
